FILE: design/assert_macros.svh
// Shared assertion shorthands for the design folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(lbl, clk, rst_n, pre, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (con)) else $error(msg);

`endif

FILE: design/rme_pkg.sv
package rme_pkg;

  localparam int ROTATION_STAGES = 16;
  localparam int CORDIC_STAGES   = (ROTATION_STAGES > 24) ? 24 : ROTATION_STAGES;
  localparam int SQRT_STAGES     = 15;

  localparam logic signed [16:0] PI_Q13      = 17'sd25736;
  localparam logic signed [16:0] HALF_PI_Q13 = 17'sd12868;
  localparam logic signed [27:0] PI_Q24      = 28'sd52707179;
  localparam logic signed [17:0] ONE_Q14     = 18'sd16384;

  localparam logic [1:0] LOCK_NONE = 2'd0;
  localparam logic [1:0] LOCK_NEG  = 2'd1;
  localparam logic [1:0] LOCK_POS  = 2'd2;

  localparam int NUM_LANES = 5;

  typedef struct packed {
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [27:0] ang;
    logic               zero;
  } lane_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m12;
    logic signed [15:0] m22;
    logic signed [16:0] zy;
    logic signed [16:0] zx;
    logic signed [15:0] s;
    logic [1:0]         lock;
  } sq_pay_t;

  typedef struct packed {
    sq_pay_t     pay;
    logic [29:0] n;
    logic [29:0] root;
  } sq_t;

  typedef struct packed {
    logic [1:0]              lock;
    lane_t [NUM_LANES-1:0]   lane;
  } cd_t;

  function automatic logic signed [27:0] atan_q24(input logic [4:0] i);
    logic signed [27:0] r;
    unique case (i)
      5'd0:  r = 28'sd13176795;
      5'd1:  r = 28'sd7778716;
      5'd2:  r = 28'sd4110060;
      5'd3:  r = 28'sd2086331;
      5'd4:  r = 28'sd1047214;
      5'd5:  r = 28'sd524117;
      5'd6:  r = 28'sd262123;
      5'd7:  r = 28'sd131069;
      5'd8:  r = 28'sd65536;
      5'd9:  r = 28'sd32768;
      5'd10: r = 28'sd16384;
      5'd11: r = 28'sd8192;
      5'd12: r = 28'sd4096;
      5'd13: r = 28'sd2048;
      5'd14: r = 28'sd1024;
      5'd15: r = 28'sd512;
      5'd16: r = 28'sd256;
      5'd17: r = 28'sd128;
      5'd18: r = 28'sd64;
      5'd19: r = 28'sd32;
      5'd20: r = 28'sd16;
      5'd21: r = 28'sd8;
      5'd22: r = 28'sd4;
      5'd23: r = 28'sd2;
      default: r = 28'sd0;
    endcase
    return r;
  endfunction

  // Fold the vector into the right half plane and scale it up.
  function automatic lane_t pre_lane(input logic signed [16:0] y, input logic signed [16:0] x);
    lane_t l;
    logic signed [16:0] vx;
    logic signed [16:0] vy;
    vx = x[16] ? -x : x;
    vy = x[16] ? -y : y;
    l.x    = {{3{vx[16]}}, vx, 14'b0};
    l.y    = {{3{vy[16]}}, vy, 14'b0};
    l.ang  = x[16] ? (y[16] ? -PI_Q24 : PI_Q24) : 28'sd0;
    l.zero = (x == 17'sd0) && (y == 17'sd0);
    return l;
  endfunction

  function automatic logic signed [16:0] round_ang(input lane_t l);
    logic signed [27:0] t;
    logic signed [16:0] r;
    t = l.ang + 28'sd1024;
    r = t[27:11];
    if (l.zero) begin
      r = 17'sd0;
    end else if (r > PI_Q13) begin
      r = PI_Q13;
    end else if (r < -PI_Q13) begin
      r = -PI_Q13;
    end
    return r;
  endfunction

  function automatic logic [17:0] abs18(input logic signed [17:0] v);
    return v[17] ? 18'(-v) : 18'(v);
  endfunction

endpackage

FILE: design/rotation_matrix_to_euler_core.sv
// Channel      | Dir | Signals                         | Content
// s_axis       | in  | tvalid tready tdata[111:0]      | m00 m01 m02 m10 m12 m20 m22
// m_axis       | out | tvalid tready tdata[55:0] tuser | angle_x angle_y angle_z, lock_case
// cfg          | in  | cfg_we_i cfg_wdata_i[10:0]      | gimbal_tolerance
//
// One matrix per cycle sustained while m_axis_tready is held high; the path
// runs through the input register, fifteen square root
// cells, pre-rotation, the CORDIC cell row, rounding and selection.
// Reset clears every valid bit and sets the tolerance to 1.
// Each stage advances when its successor is empty or advancing, so bubbles
// collapse and input keeps flowing while a result waits, until every stage is full.
`include "assert_macros.svh"

module rotation_matrix_to_euler_core import rme_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [10:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // m00, m01, m02, m10, m12, m20, m22 (16 bits each) from bit 0 up
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // angle_x[16:0], angle_y[32:17], angle_z[48:33], zero fill
  output logic [55:0]  m_axis_tdata,
  // lock_case[1:0]
  output logic [1:0]   m_axis_tuser
);

  logic [10:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= 11'd1;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // Input stage: lock test, asin operand clamp and square.
  logic signed [15:0] m00, m01, m02, m10, m12, m20, m22;
  logic signed [17:0] d_neg, d_pos;
  logic [1:0]         lock_w;
  logic signed [15:0] s_w;
  sq_pay_t            pay_w;

  assign m00 = s_axis_tdata[15:0];
  assign m01 = s_axis_tdata[31:16];
  assign m02 = s_axis_tdata[47:32];
  assign m10 = s_axis_tdata[63:48];
  assign m12 = s_axis_tdata[79:64];
  assign m20 = s_axis_tdata[95:80];
  assign m22 = s_axis_tdata[111:96];

  assign d_neg = 18'(m02) + ONE_Q14;
  assign d_pos = 18'(m02) - ONE_Q14;

  always_comb begin
    priority if ({7'b0, tol_q} > abs18(d_neg)) begin
      lock_w = LOCK_NEG;
    end else if ({7'b0, tol_q} > abs18(d_pos)) begin
      lock_w = LOCK_POS;
    end else begin
      lock_w = LOCK_NONE;
    end
    if (18'(m02) > ONE_Q14) begin
      s_w = 16'sd16384;
    end else if (18'(m02) < -ONE_Q14) begin
      s_w = -16'sd16384;
    end else begin
      s_w = m02;
    end
    pay_w.m00  = m00;
    pay_w.m01  = m01;
    pay_w.m12  = m12;
    pay_w.m22  = m22;
    pay_w.s    = s_w;
    pay_w.lock = lock_w;
    unique case (lock_w)
      LOCK_NEG: begin
        pay_w.zy = 17'(m10);
        pay_w.zx = 17'(m20);
      end
      LOCK_POS: begin
        pay_w.zy = -17'(m10);
        pay_w.zx = -17'(m20);
      end
      default: begin
        pay_w.zy = 17'(m01);
        pay_w.zx = 17'(m00);
      end
    endcase
  end

  logic        v0_q;
  sq_pay_t     pay0_q;
  logic [29:0] sqr0_q;
  logic        rdy0;

  logic        sq_vld [SQRT_STAGES+1];
  logic        sq_rdy [SQRT_STAGES+1];
  sq_t         sq_dat [SQRT_STAGES+1];

  assign rdy0          = !v0_q || sq_rdy[0];
  assign s_axis_tready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid) begin
      pay0_q <= pay_w;
      sqr0_q <= 30'(32'(s_w) * 32'(s_w));
    end
  end

  assign sq_vld[0]      = v0_q;
  assign sq_dat[0].pay  = pay0_q;
  assign sq_dat[0].n    = 30'(1 << 28) - sqr0_q;
  assign sq_dat[0].root = 30'd0;

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
    rme_sqrt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (4'(k)),
      .in_valid_i (sq_vld[k]),
      .in_ready_o (sq_rdy[k]),
      .in_data_i  (sq_dat[k]),
      .out_valid_o(sq_vld[k+1]),
      .out_ready_i(sq_rdy[k+1]),
      .out_data_o (sq_dat[k+1])
    );
  end

  // Pre-rotation stage feeding the CORDIC row.
  logic    cd_vld [CORDIC_STAGES+1];
  logic    cd_rdy [CORDIC_STAGES+1];
  cd_t     cd_dat [CORDIC_STAGES+1];
  logic    vp_q;
  cd_t     pre_q, pre_d;
  sq_pay_t sp;

  assign sp = sq_dat[SQRT_STAGES].pay;
  assign sq_rdy[SQRT_STAGES] = !vp_q || cd_rdy[0];

  always_comb begin
    pre_d.lock    = sp.lock;
    pre_d.lane[0] = pre_lane(17'(sp.s), 17'(sq_dat[SQRT_STAGES].root[15:0]));
    pre_d.lane[1] = pre_lane(17'(sp.m12), 17'(sp.m22));
    pre_d.lane[2] = pre_lane(-17'(sp.m12), -17'(sp.m22));
    pre_d.lane[3] = pre_lane(sp.zy, sp.zx);
    pre_d.lane[4] = pre_lane(-17'(sp.m01), -17'(sp.m00));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else if (sq_rdy[SQRT_STAGES]) begin
      vp_q <= sq_vld[SQRT_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sq_rdy[SQRT_STAGES] && sq_vld[SQRT_STAGES]) begin
      pre_q <= pre_d;
    end
  end

  assign cd_vld[0] = vp_q;
  assign cd_dat[0] = pre_q;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    rme_cordic_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .step_i     (5'(k)),
      .in_valid_i (cd_vld[k]),
      .in_ready_o (cd_rdy[k]),
      .in_data_i  (cd_dat[k]),
      .out_valid_o(cd_vld[k+1]),
      .out_ready_i(cd_rdy[k+1]),
      .out_data_o (cd_dat[k+1])
    );
  end

  // Rounding stage.
  logic               vr_q;
  logic [1:0]         lock_r_q;
  logic signed [16:0] ang_r_q [NUM_LANES];
  logic               rdy_r;
  logic               rdy_o;

  assign rdy_r = !vr_q || rdy_o;
  assign cd_rdy[CORDIC_STAGES] = rdy_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vr_q <= 1'b0;
    end else if (rdy_r) begin
      vr_q <= cd_vld[CORDIC_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_r && cd_vld[CORDIC_STAGES]) begin
      lock_r_q <= cd_dat[CORDIC_STAGES].lock;
      for (int l = 0; l < NUM_LANES; l++) begin
        ang_r_q[l] <= round_ang(cd_dat[CORDIC_STAGES].lane[l]);
      end
    end
  end

  // Selection and output register.
  logic signed [17:0] x1, x2;
  logic [19:0]        sum1, sum2;
  logic signed [16:0] ax_d;
  logic signed [15:0] ay_d, az_d;
  logic               vo_q;
  logic signed [16:0] ax_q;
  logic signed [15:0] ay_q, az_q;
  logic [1:0]         lock_o_q;

  assign x1   = -18'(ang_r_q[0]);
  assign x2   = 18'(PI_Q13) - x1;
  assign sum1 = 20'(abs18(x1)) + 20'(abs18(18'(ang_r_q[1]))) + 20'(abs18(18'(ang_r_q[3])));
  assign sum2 = 20'(abs18(x2)) + 20'(abs18(18'(ang_r_q[2]))) + 20'(abs18(18'(ang_r_q[4])));

  always_comb begin
    unique case (lock_r_q)
      LOCK_NEG: begin
        ax_d = 17'sd0;
        ay_d = HALF_PI_Q13[15:0];
        az_d = ang_r_q[3][15:0];
      end
      LOCK_POS: begin
        ax_d = 17'sd0;
        ay_d = 16'(-HALF_PI_Q13);
        az_d = ang_r_q[3][15:0];
      end
      default: begin
        if (sum1 <= sum2) begin
          ax_d = x1[16:0];
          ay_d = ang_r_q[1][15:0];
          az_d = ang_r_q[3][15:0];
        end else begin
          ax_d = x2[16:0];
          ay_d = ang_r_q[2][15:0];
          az_d = ang_r_q[4][15:0];
        end
      end
    endcase
  end

  assign rdy_o = !vo_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vo_q <= 1'b0;
    end else if (rdy_o) begin
      vo_q <= vr_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && vr_q) begin
      ax_q     <= ax_d;
      ay_q     <= ay_d;
      az_q     <= az_d;
      lock_o_q <= lock_r_q;
    end
  end

  assign m_axis_tvalid = vo_q;
  assign m_axis_tdata  = {7'b0, az_q, ay_q, ax_q};
  assign m_axis_tuser  = lock_o_q;

  `ASSERT_IMPLIES(a_lock_x_zero, clk_i, rst_ni, m_axis_tvalid && (m_axis_tuser != LOCK_NONE),
    ax_q == 17'sd0, "lock result with nonzero x angle")
  `ASSERT_IMPLIES(a_lock_code, clk_i, rst_ni, m_axis_tvalid,
    (m_axis_tuser == LOCK_NONE) || (m_axis_tuser == LOCK_NEG) || (m_axis_tuser == LOCK_POS),
    "lock_case out of range")
  `ASSERT_IMPLIES(a_z_range, clk_i, rst_ni, m_axis_tvalid,
    (17'(az_q) <= PI_Q13) && (17'(az_q) >= -PI_Q13), "z angle beyond pi")
  `ASSERT_ALWAYS(a_rounded_range, clk_i, rst_ni,
    !vr_q || ((ang_r_q[0] <= PI_Q13) && (ang_r_q[0] >= -PI_Q13)), "asin angle beyond pi")

endmodule

FILE: design/rme_sqrt_cell.sv
module rme_sqrt_cell import rme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [3:0] step_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  sq_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output sq_t        out_data_o
);

  logic        valid_q;
  sq_t         data_q, data_d;
  logic [29:0] bit_w;
  logic [29:0] trial;

  assign in_ready_o = !valid_q || out_ready_i;
  assign bit_w      = 30'(1) << (5'd28 - {step_i, 1'b0});
  assign trial      = in_data_i.root + bit_w;

  always_comb begin
    data_d = in_data_i;
    if (in_data_i.n >= trial) begin
      data_d.n    = in_data_i.n - trial;
      data_d.root = (in_data_i.root >> 1) + bit_w;
    end else begin
      data_d.root = in_data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

FILE: design/rme_cordic_cell.sv
module rme_cordic_cell import rme_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [4:0] step_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cd_t        in_data_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output cd_t        out_data_o
);

  logic               valid_q;
  cd_t                data_q, data_d;
  logic signed [27:0] step_ang;

  assign in_ready_o = !valid_q || out_ready_i;
  assign step_ang   = atan_q24(step_i);

  // Rotate every lane toward the x axis by one step.
  always_comb begin
    data_d = in_data_i;
    for (int l = 0; l < NUM_LANES; l++) begin
      if (!in_data_i.lane[l].y[33]) begin
        data_d.lane[l].x   = in_data_i.lane[l].x + (in_data_i.lane[l].y >>> step_i);
        data_d.lane[l].y   = in_data_i.lane[l].y - (in_data_i.lane[l].x >>> step_i);
        data_d.lane[l].ang = in_data_i.lane[l].ang + step_ang;
      end else begin
        data_d.lane[l].x   = in_data_i.lane[l].x - (in_data_i.lane[l].y >>> step_i);
        data_d.lane[l].y   = in_data_i.lane[l].y + (in_data_i.lane[l].x >>> step_i);
        data_d.lane[l].ang = in_data_i.lane[l].ang - step_ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      data_q <= data_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule
